@@ rtl/fan_channel_spinup_stall_control_unit_assert.svh @@
// Assertion macros for the fan channel control top level.
`ifndef FAN_CHANNEL_SPINUP_STALL_CONTROL_UNIT_ASSERT_SVH
`define FAN_CHANNEL_SPINUP_STALL_CONTROL_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property must hold on every clock edge outside reset.
`define FCS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fcs assertion failed");
// Condition must never be seen outside reset.
`define FCS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("fcs forbidden condition seen");
`else
`define FCS_ASSERT(lbl, prop)
`define FCS_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ rtl/fcs_pkg.sv @@
// Types, codes and constants for the fan channel spin-up and stall control.
`timescale 1ns / 1ps
`default_nettype none

package fcs_pkg;

  localparam int unsigned PWM_FULL_SCALE = 255;
  localparam int unsigned PCT_CAP        = 100;
  // x / 100 == (x * 5243) >> 19 for every x below 43690
  localparam int unsigned RECIP_HUNDRED  = 5243;
  localparam int unsigned PCT_SHIFT      = 19;
  localparam int unsigned PCT_MUL        = PWM_FULL_SCALE * RECIP_HUNDRED;
  localparam int unsigned PCT_W          = 7;
  localparam int unsigned PROD_W         = 28;

  typedef enum logic [1:0] {
    ACT_SET_DUTY    = 2'd0,
    ACT_SET_PERCENT = 2'd1,
    ACT_TICK        = 2'd2,
    ACT_SET_MANUAL  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_START       = 3'd0,
    EV_STALL       = 3'd1,
    EV_STALL_CLEAR = 3'd2,
    EV_MANUAL      = 3'd3,
    EV_AUTO        = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    CFG_CHANNEL_ID   = 3'd0,
    CFG_DUTY_FLOOR   = 3'd1,
    CFG_DUTY_CEILING = 3'd2,
    CFG_ENABLED      = 3'd3,
    CFG_STALL_FLOOR  = 3'd4,
    CFG_KICK_DUTY    = 3'd5,
    CFG_KICK_TIME    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  channel_id;
    logic [7:0]  duty_floor;
    logic [7:0]  duty_ceiling;
    logic        channel_enabled;
    logic [15:0] stall_rpm_floor;
    logic [7:0]  kick_duty;
    logic [15:0] kick_time_ms;
  } cfg_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  target_id;
    logic [7:0]  level;
    logic        manual_on;
    logic [31:0] time_ms;
    logic [15:0] measured_rpm;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        pwm_write;
    logic [7:0]  pwm_level;
    logic        event_valid;
    ev_kind_t    event_kind;
    logic [7:0]  event_channel;
    logic [15:0] event_rpm;
    logic [7:0]  event_level;
    logic [31:0] event_time;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/fan_channel_spinup_stall_control_unit.sv @@
// Top level of the fan channel spin-up and stall control block.
// Input channel: in_valid / in_stall / in_data carry one request or tachometer
// tick per beat. Output channel: out_valid / out_stall / out_data carry exactly
// one result beat per input beat, in order.
// Configuration: cfg_we writes cfg_data into register cfg_idx at the clock
// edge; write only while no beat is in flight.
// Path: an accepted input beat is held in the input register, then its result
// moves into the result register and out_valid rises; a stalled output can
// hold the beat in the input register. Throughput: one beat per cycle while
// out_stall is low; the single decision stage between the registers sets it.
// A stalled output holds its beat; the input register then holds too and
// in_stall rises, so nothing is dropped.
// Reset (rst, synchronous) empties both registers, clears the channel state
// and loads the configuration defaults: id 0, min duty 0, max duty 255,
// channel enabled, stall floor 300 RPM, kick duty 255, kick time 1000 ms.
`timescale 1ns / 1ps
`default_nettype none

`include "fan_channel_spinup_stall_control_unit_assert.svh"

module fan_channel_spinup_stall_control_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcs_pkg::out_item_t  out_data
);

  fcs_pkg::cfg_t      cfg;
  fcs_pkg::in_item_t  in_hold;
  logic               in_hold_valid;
  logic               advance;
  fcs_pkg::out_item_t result;
  logic               reject_noisy;
  logic               stall_ev_unleveled;
  logic               idle_fields_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_id      <= 8'd0;
      cfg.duty_floor      <= 8'd0;
      cfg.duty_ceiling    <= 8'd255;
      cfg.channel_enabled <= 1'b1;
      cfg.stall_rpm_floor <= 16'd300;
      cfg.kick_duty       <= 8'd255;
      cfg.kick_time_ms    <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_idx)
        fcs_pkg::CFG_CHANNEL_ID:   cfg.channel_id      <= cfg_data[7:0];
        fcs_pkg::CFG_DUTY_FLOOR:   cfg.duty_floor      <= cfg_data[7:0];
        fcs_pkg::CFG_DUTY_CEILING: cfg.duty_ceiling    <= cfg_data[7:0];
        fcs_pkg::CFG_ENABLED:      cfg.channel_enabled <= cfg_data[0];
        fcs_pkg::CFG_STALL_FLOOR:  cfg.stall_rpm_floor <= cfg_data;
        fcs_pkg::CFG_KICK_DUTY:    cfg.kick_duty       <= cfg_data[7:0];
        fcs_pkg::CFG_KICK_TIME:    cfg.kick_time_ms    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // move the held beat into the result register when that slot frees up
  assign advance  = in_hold_valid && (!out_valid || !out_stall);
  assign in_stall = in_hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold_valid <= 1'b0;
    end else if (!in_stall) begin
      in_hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_hold <= in_data;
    end
  end

  fcs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_hold),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign reject_noisy = out_valid && out_data.status &&
                        (out_data.pwm_write || out_data.event_valid);
  assign stall_ev_unleveled = out_valid && out_data.event_valid &&
                              out_data.event_kind == fcs_pkg::EV_STALL &&
                              out_data.event_level == 8'd0;
  assign idle_fields_set = out_valid && !out_data.event_valid &&
                           (out_data.event_time != 32'd0 ||
                            out_data.event_channel != 8'd0 ||
                            out_data.event_rpm != 16'd0);

  `FCS_ASSERT(a_advance_fills_out, advance |=> out_valid)
  `FCS_ASSERT_NEVER(a_reject_is_quiet, reject_noisy)
  `FCS_ASSERT_NEVER(a_stall_has_level, stall_ev_unleveled)
  `FCS_ASSERT_NEVER(a_no_event_zero, idle_fields_set)

endmodule

`default_nettype wire

@@ rtl/fcs_duty.sv @@
// Duty request decode: percent scaling and min/max clamping.
`timescale 1ns / 1ps
`default_nettype none

module fcs_duty (
  input  fcs_pkg::action_t action,
  input  logic [7:0]       level,
  input  logic [7:0]       duty_floor,
  input  logic [7:0]       duty_ceiling,
  output logic [7:0]       duty
);

  logic [fcs_pkg::PCT_W-1:0]  pct;
  logic [fcs_pkg::PROD_W-1:0] prod;
  logic [7:0]                 raw;
  logic [7:0]                 floored;

  always_comb begin
    // saturate at one hundred percent before scaling
    if (level > 8'(fcs_pkg::PCT_CAP)) begin
      pct = fcs_pkg::PCT_W'(fcs_pkg::PCT_CAP);
    end else begin
      pct = level[fcs_pkg::PCT_W-1:0];
    end
    prod = fcs_pkg::PROD_W'(pct) * fcs_pkg::PROD_W'(fcs_pkg::PCT_MUL);

    if (action == fcs_pkg::ACT_SET_PERCENT) begin
      raw = prod[fcs_pkg::PCT_SHIFT +: 8];
    end else begin
      raw = level;
    end

    // apply min first, then max, so max wins when they cross
    if (raw != 8'd0 && raw < duty_floor) begin
      floored = duty_floor;
    end else begin
      floored = raw;
    end
    if (floored > duty_ceiling) begin
      duty = duty_ceiling;
    end else begin
      duty = floored;
    end
  end

endmodule

`default_nettype wire

@@ rtl/fcs_core.sv @@
// Channel state and per-beat decision logic for spin-up, stall and mode.
`timescale 1ns / 1ps
`default_nettype none

module fcs_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  fcs_pkg::in_item_t item,
  input  fcs_pkg::cfg_t     cfg,
  output fcs_pkg::out_item_t result
);

  logic [7:0]  target_level, target_level_next;
  logic [15:0] last_rpm, last_rpm_next;
  logic        kicking, kicking_next;
  logic [31:0] kick_start, kick_start_next;
  logic        stall_flag, stall_flag_next;
  logic        manual_mode, manual_mode_next;

  logic [7:0]  duty;
  logic [31:0] kick_elapsed;
  logic        kick_done;
  logic        rpm_low;

  fcs_duty u_duty (
    .action       (item.action),
    .level        (item.level),
    .duty_floor   (cfg.duty_floor),
    .duty_ceiling (cfg.duty_ceiling),
    .duty         (duty)
  );

  always_comb begin
    target_level_next = target_level;
    last_rpm_next     = last_rpm;
    kicking_next      = kicking;
    kick_start_next   = kick_start;
    stall_flag_next   = stall_flag;
    manual_mode_next  = manual_mode;
    result            = '0;

    kick_elapsed = item.time_ms - kick_start;
    kick_done    = kick_elapsed >= {16'd0, cfg.kick_time_ms};
    rpm_low      = item.measured_rpm < cfg.stall_rpm_floor;

    if (item.action == fcs_pkg::ACT_TICK) begin
      if (cfg.channel_enabled) begin
        last_rpm_next = item.measured_rpm;
        if (kicking) begin
          // end spin-up and hand over to the held target duty
          if (kick_done) begin
            kicking_next     = 1'b0;
            result.pwm_write = 1'b1;
            result.pwm_level = target_level;
          end
        end else if (target_level > cfg.duty_floor && rpm_low) begin
          if (!stall_flag) begin
            stall_flag_next      = 1'b1;
            result.event_valid   = 1'b1;
            result.event_kind    = fcs_pkg::EV_STALL;
            result.event_channel = cfg.channel_id;
            result.event_rpm     = item.measured_rpm;
            result.event_level   = target_level;
            result.event_time    = item.time_ms;
          end
        end else if (stall_flag && !rpm_low) begin
          stall_flag_next      = 1'b0;
          result.event_valid   = 1'b1;
          result.event_kind    = fcs_pkg::EV_STALL_CLEAR;
          result.event_channel = cfg.channel_id;
          result.event_rpm     = item.measured_rpm;
          result.event_time    = item.time_ms;
        end
      end
    end else if (item.target_id != cfg.channel_id) begin
      result.status = 1'b1;
    end else if (item.action == fcs_pkg::ACT_SET_MANUAL) begin
      manual_mode_next     = item.manual_on;
      result.event_valid   = 1'b1;
      result.event_kind    = item.manual_on ? fcs_pkg::EV_MANUAL : fcs_pkg::EV_AUTO;
      result.event_channel = cfg.channel_id;
      result.event_time    = item.time_ms;
      if (item.manual_on) begin
        result.pwm_write = 1'b1;
        result.pwm_level = item.level;
      end
    end else if (manual_mode) begin
      result.status = 1'b1;
    end else if (duty != 8'd0 && !kicking && last_rpm < cfg.stall_rpm_floor &&
                 target_level == 8'd0) begin
      // stopped fan: kick first, keep the requested duty for later
      kicking_next         = 1'b1;
      kick_start_next      = item.time_ms;
      target_level_next    = duty;
      result.pwm_write     = 1'b1;
      result.pwm_level     = cfg.kick_duty;
      result.event_valid   = 1'b1;
      result.event_kind    = fcs_pkg::EV_START;
      result.event_channel = cfg.channel_id;
      result.event_time    = item.time_ms;
    end else begin
      target_level_next = duty;
      result.pwm_write  = 1'b1;
      result.pwm_level  = duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= '0;
      last_rpm     <= '0;
      kicking      <= 1'b0;
      kick_start   <= '0;
      stall_flag   <= 1'b0;
      manual_mode  <= 1'b0;
    end else if (step) begin
      target_level <= target_level_next;
      last_rpm     <= last_rpm_next;
      kicking      <= kicking_next;
      kick_start   <= kick_start_next;
      stall_flag   <= stall_flag_next;
      manual_mode  <= manual_mode_next;
    end
  end

endmodule

`default_nettype wire
